// ----- src/arp_cache_responder_defines.svh -----
// Assertion macros used by the ARP cache responder top level.
`ifndef ARP_CACHE_RESPONDER_DEFINES_SVH
`define ARP_CACHE_RESPONDER_DEFINES_SVH

`ifndef NO_ASSERTIONS

// Same-cycle implication checked on every rising clock edge out of reset.
`define ARP_ASSERT_IMPLIES(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed: same-cycle implication");

// Next-cycle implication checked on every rising clock edge out of reset.
`define ARP_ASSERT_NEXT(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle implication");

`else

`define ARP_ASSERT_IMPLIES(name, clk, rst_n, ante, cons)

`define ARP_ASSERT_NEXT(name, clk, rst_n, ante, cons)

`endif

`endif

// ----- src/arp_pkg.sv -----
// Shared types and constants of the ARP cache responder.
package arp_pkg;

    // Header field values that a valid request carries.
    localparam logic [15:0] HW_ETHERNET    = 16'h0001;
    localparam logic [15:0] PROTO_IPV4     = 16'h0800;
    localparam logic [15:0] OPCODE_REQUEST = 16'h0001;

    // Reset value of the static host entry MAC.
    localparam logic [47:0] HOST_MAC_RESET = 48'hcafe33538287;

    // Request kinds.
    localparam logic KIND_PACKET = 1'b0;
    localparam logic KIND_LOOKUP = 1'b1;

    // Result status codes.
    localparam logic [2:0] ST_OK          = 3'd0;
    localparam logic [2:0] ST_BAD_HW      = 3'd1;
    localparam logic [2:0] ST_BAD_PROTO   = 3'd2;
    localparam logic [2:0] ST_NOT_OURS    = 3'd3;
    localparam logic [2:0] ST_NOT_REQUEST = 3'd4;
    localparam logic [2:0] ST_LOOKUP_MISS = 3'd5;

    // Operations handed from the classifier to the table engine.
    localparam logic [1:0] OP_REJECT = 2'd0;
    localparam logic [1:0] OP_LEARN  = 2'd1;
    localparam logic [1:0] OP_LOOKUP = 2'd2;

    // Configuration register indexes.
    localparam int CFG_IDX_W = 3;
    localparam logic [CFG_IDX_W-1:0] CFG_MY_IP    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MY_MAC   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_HOST_IP  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_HOST_MAC = 3'd3;

    // Depth of the command queue between classifier and table engine.
    localparam int QUEUE_DEPTH = 2;

    // Classified request waiting for the table engine.
    typedef struct packed {
        logic [1:0]  op;
        logic [2:0]  status;
        logic [31:0] ip;
        logic [47:0] mac;
    } arp_cmd_t;

    // One result as driven on the output ports.
    typedef struct packed {
        logic        valid;
        logic [2:0]  status;
        logic        table_full;
        logic        send_reply;
        logic [47:0] eth_dest_mac;
        logic [47:0] reply_target_mac;
        logic [31:0] reply_target_ip;
        logic [47:0] lookup_mac;
    } arp_result_t;

endpackage

// ----- src/arp_front.sv -----
// Request classifier: header checks and operation selection.
module arp_front
    import arp_pkg::*;
(
    input  logic        kind,
    input  logic [15:0] hw_type,
    input  logic [15:0] proto_type,
    input  logic [15:0] opcode,
    input  logic [31:0] sender_ip,
    input  logic [47:0] sender_mac,
    input  logic [31:0] dest_ip,
    input  logic [31:0] query_ip,
    input  logic [31:0] my_ip,
    output arp_cmd_t    cmd
);

    // Checks run in priority order; a packet that passes the header checks
    // is always handed on to be learned, and its final status is settled here already.
    always_comb
    begin
        cmd.mac = sender_mac;
        cmd.ip  = sender_ip;
        if (kind == KIND_LOOKUP)
        begin
            cmd.op     = OP_LOOKUP;
            cmd.status = ST_OK;
            cmd.ip     = query_ip;
        end
        else if (hw_type != HW_ETHERNET)
        begin
            cmd.op     = OP_REJECT;
            cmd.status = ST_BAD_HW;
        end
        else if (proto_type != PROTO_IPV4)
        begin
            cmd.op     = OP_REJECT;
            cmd.status = ST_BAD_PROTO;
        end
        else
        begin
            cmd.op = OP_LEARN;
            if (dest_ip != my_ip)
            begin
                cmd.status = ST_NOT_OURS;
            end
            else if (opcode != OPCODE_REQUEST)
            begin
                cmd.status = ST_NOT_REQUEST;
            end
            else
            begin
                cmd.status = ST_OK;
            end
        end
    end

endmodule

// ----- src/arp_queue.sv -----
// Small command queue between the classifier and the table engine.
module arp_queue
    import arp_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     push,
    input  arp_cmd_t push_cmd,
    input  logic     pop,
    output arp_cmd_t head,
    output logic     full,
    output logic     empty
);

    localparam int QPTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;

    arp_cmd_t          entry_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg;
    logic [QPTR_W-1:0] wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg;
    logic [QPTR_W-1:0] rd_ptr_next;
    logic [QPTR_W:0]   count_reg;
    logic [QPTR_W:0]   count_next;

    assign full  = (count_reg == (QPTR_W+1)'(QUEUE_DEPTH));
    assign empty = (count_reg == '0);
    assign head  = entry_reg[rd_ptr_reg];

    // Pointer and fill bookkeeping; the depth is a power of two so the
    // pointers wrap on their own.
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Queue storage.
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule

// ----- src/arp_back.sv -----
// Table engine: scans the cache one slot per cycle, learns and resolves.
module arp_back
    import arp_pkg::*;
#(
    parameter int TABLE_ENTRIES = 16
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        q_empty,
    input  arp_cmd_t    q_head,
    input  logic [31:0] host_ip,
    input  logic [47:0] host_mac,
    output logic        pop,
    output arp_result_t result
);

    // The last slot is always the static host entry and lives in the
    // configuration registers; the rest are dynamic and fill from slot 0
    // upward without ever being freed, so a fill count marks the used ones.
    localparam int DYN   = TABLE_ENTRIES - 1;
    localparam int IDX_W = (DYN > 1) ? $clog2(DYN) : 1;
    localparam int CNT_W = $clog2(DYN + 1);
    localparam logic [CNT_W-1:0] DYN_CNT = CNT_W'(DYN);

    localparam logic S_IDLE = 1'b0;
    localparam logic S_SCAN = 1'b1;

    logic [31:0]      mem_ip  [DYN];
    logic [47:0]      mem_mac [DYN];
    logic [31:0]      rd_ip_reg;
    logic [47:0]      rd_mac_reg;
    logic [IDX_W-1:0] rd_addr;
    logic             wr_en;
    logic [IDX_W-1:0] wr_addr;

    logic             state_reg;
    logic             state_next;
    arp_cmd_t         cmd_reg;
    arp_cmd_t         cmd_next;
    logic [CNT_W-1:0] idx_reg;
    logic [CNT_W-1:0] idx_next;
    logic [CNT_W-1:0] fill_reg;
    logic [CNT_W-1:0] fill_next;
    arp_result_t      res_reg;
    arp_result_t      res_next;

    logic             at_end;
    logic             slot_hit;
    logic             host_hit;
    logic             has_room;
    logic             learn_done;
    logic             learn_full;
    logic             learn_host;

    assign at_end   = (idx_reg == fill_reg);
    assign slot_hit = (rd_ip_reg == cmd_reg.ip);
    assign host_hit = (host_ip == cmd_reg.ip);
    assign has_room = (fill_reg != DYN_CNT);
    assign wr_addr  = idx_reg[IDX_W-1:0];
    assign rd_addr  = (idx_next < DYN_CNT) ? idx_next[IDX_W-1:0] : '0;
    assign result   = res_reg;

    // Sequencer: pop a command, answer a reject directly, else walk the used slots, then the host slot.
    always_comb
    begin
        state_next = state_reg;
        cmd_next   = cmd_reg;
        idx_next   = idx_reg;
        fill_next  = fill_reg;
        res_next   = '0;
        pop        = 1'b0;
        wr_en      = 1'b0;
        learn_done = 1'b0;
        learn_full = 1'b0;
        learn_host = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                if (!q_empty)
                begin
                    pop      = 1'b1;
                    cmd_next = q_head;
                    idx_next = '0;
                    if (q_head.op == OP_REJECT)
                    begin
                        res_next.valid  = 1'b1;
                        res_next.status = q_head.status;
                    end
                    else
                    begin
                        state_next = S_SCAN;
                    end
                end
            end
            S_SCAN:
            begin
                if (cmd_reg.op == OP_LEARN)
                begin
                    if (at_end)
                    begin
                        learn_done = 1'b1;
                        if (has_room)
                        begin
                            wr_en     = 1'b1;
                            fill_next = fill_reg + 1'b1;
                        end
                        else
                        begin
                            learn_full = !host_hit;
                            learn_host = host_hit;
                        end
                    end
                    else if (slot_hit)
                    begin
                        // Refresh of a dynamic entry rewrites the same address.
                        learn_done = 1'b1;
                        wr_en      = 1'b1;
                    end
                    else
                    begin
                        idx_next = idx_reg + 1'b1;
                    end
                end
                else
                begin
                    if (at_end)
                    begin
                        state_next     = S_IDLE;
                        res_next.valid = 1'b1;
                        if (host_hit)
                        begin
                            res_next.status     = ST_OK;
                            res_next.lookup_mac = host_mac;
                        end
                        else
                        begin
                            res_next.status = ST_LOOKUP_MISS;
                        end
                    end
                    else if (slot_hit)
                    begin
                        state_next          = S_IDLE;
                        res_next.valid      = 1'b1;
                        res_next.status     = ST_OK;
                        res_next.lookup_mac = rd_mac_reg;
                    end
                    else
                    begin
                        idx_next = idx_reg + 1'b1;
                    end
                end
                // A learned sender resolves to its own MAC unless the dynamic slots are
                // full and only the static host entry matched it.
                if (learn_done)
                begin
                    state_next          = S_IDLE;
                    res_next.valid      = 1'b1;
                    res_next.status     = cmd_reg.status;
                    res_next.table_full = learn_full;
                    if (cmd_reg.status == ST_OK)
                    begin
                        res_next.send_reply       = 1'b1;
                        res_next.eth_dest_mac     = learn_host ? host_mac : cmd_reg.mac;
                        res_next.reply_target_mac = cmd_reg.mac;
                        res_next.reply_target_ip  = cmd_reg.ip;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control state and result register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            idx_reg   <= '0;
            fill_reg  <= '0;
            res_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            idx_reg   <= idx_next;
            fill_reg  <= fill_next;
            res_reg   <= res_next;
        end
    end

    // Command payload.
    always_ff @(posedge clk)
    begin
        cmd_reg <= cmd_next;
    end

    // Slot memory: one write port, one registered read port.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_ip[wr_addr]  <= cmd_reg.ip;
            mem_mac[wr_addr] <= cmd_reg.mac;
        end
        rd_ip_reg  <= mem_ip[rd_addr];
        rd_mac_reg <= mem_mac[rd_addr];
    end

endmodule

// ----- src/arp_cache_responder.sv -----
// Top level of the ARP cache responder.
//
// Requests enter on start with busy low; kind selects a decoded ARP packet
// or a lookup of query_ip. A classifier checks the header and queues the
// request in a two-entry command queue; busy is high while it is full.
// The table engine takes one request at a time and walks the cache one
// slot per cycle through a slot memory with one write and one read port.
// Every request yields exactly one result, shown for one cycle with
// result_valid high; fields that do not apply read zero. Results cannot
// be held off.
// A packet failing the header checks is answered when the engine pops
// it, without a scan; a learn or lookup walks the used slots, of which
// there are at most TABLE_ENTRIES - 1. The engine finishes one request
// before it takes the next; queued requests wait for those ahead.
// Configuration writes are always ready; the user must issue them only
// while the block is idle, which the block itself does not enforce.
// Writes to index 1 are accepted and have no effect on results.
// Reset empties the queue and forgets all learned entries at once; the
// last slot is the static host entry and follows host_ip and host_mac.
`include "arp_cache_responder_defines.svh"

module arp_cache_responder
    import arp_pkg::*;
#(
    parameter int TABLE_ENTRIES = 16
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    output logic                 busy,
    input  logic                 kind,
    input  logic [15:0]          hw_type,
    input  logic [15:0]          proto_type,
    input  logic [15:0]          opcode,
    input  logic [31:0]          sender_ip,
    input  logic [47:0]          sender_mac,
    input  logic [31:0]          dest_ip,
    input  logic [31:0]          query_ip,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [47:0]          cfg_data,
    output logic                 result_valid,
    output logic [2:0]           status,
    output logic                 table_full,
    output logic                 send_reply,
    output logic [47:0]          eth_dest_mac,
    output logic [47:0]          reply_target_mac,
    output logic [31:0]          reply_target_ip,
    output logic [47:0]          lookup_mac
);

    logic [31:0] my_ip_reg;
    logic [31:0] host_ip_reg;
    logic [47:0] host_mac_reg;
    logic        cfg_write;
    logic        push;
    logic        pop;
    logic        q_full;
    logic        q_empty;
    arp_cmd_t    front_cmd;
    arp_cmd_t    q_head;
    arp_result_t result;
    logic        learn_status;
    logic        miss_result;
    logic        host_ip_wr;

    assign cfg_ready = 1'b1;
    assign cfg_write = cfg_valid && cfg_ready;
    assign busy      = q_full;
    assign push      = start && !busy;

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            my_ip_reg    <= '0;
            host_ip_reg  <= '0;
            host_mac_reg <= HOST_MAC_RESET;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                CFG_MY_IP:    my_ip_reg    <= cfg_data[31:0];
                CFG_HOST_IP:  host_ip_reg  <= cfg_data[31:0];
                CFG_HOST_MAC: host_mac_reg <= cfg_data;
                default:
                begin
                end
            endcase
        end
    end

    // Header checks and operation selection.
    arp_front u_front (
        .kind       (kind),
        .hw_type    (hw_type),
        .proto_type (proto_type),
        .opcode     (opcode),
        .sender_ip  (sender_ip),
        .sender_mac (sender_mac),
        .dest_ip    (dest_ip),
        .query_ip   (query_ip),
        .my_ip      (my_ip_reg),
        .cmd        (front_cmd)
    );

    // Decoupling queue.
    arp_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_cmd (front_cmd),
        .pop      (pop),
        .head     (q_head),
        .full     (q_full),
        .empty    (q_empty)
    );

    // Cache scan and result generation.
    arp_back #(
        .TABLE_ENTRIES (TABLE_ENTRIES)
    ) u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .q_empty  (q_empty),
        .q_head   (q_head),
        .host_ip  (host_ip_reg),
        .host_mac (host_mac_reg),
        .pop      (pop),
        .result   (result)
    );

    // Result ports.
    assign result_valid     = result.valid;
    assign status           = result.status;
    assign table_full       = result.table_full;
    assign send_reply       = result.send_reply;
    assign eth_dest_mac     = result.eth_dest_mac;
    assign reply_target_mac = result.reply_target_mac;
    assign reply_target_ip  = result.reply_target_ip;
    assign lookup_mac       = result.lookup_mac;

    // Conditions watched by the checks below.
    assign learn_status = (status != ST_BAD_HW) && (status != ST_BAD_PROTO) &&
                          (status != ST_LOOKUP_MISS);
    assign miss_result  = result_valid && (status == ST_LOOKUP_MISS);
    assign host_ip_wr   = cfg_write && (cfg_index == CFG_HOST_IP);

    // A reply goes out only with a strobe and an ok status.
    `ARP_ASSERT_IMPLIES(a_reply_ok, clk, rst_n, send_reply, result_valid && status == ST_OK)

    // Only packets that passed the header checks can report a full table.
    `ARP_ASSERT_IMPLIES(a_full_learned, clk, rst_n, table_full, result_valid && learn_status)

    // A lookup miss carries no MAC and no reply.
    `ARP_ASSERT_IMPLIES(a_miss_clean, clk, rst_n, miss_result, lookup_mac == '0 && !send_reply)

    // A host address write lands in the static entry on the next cycle.
    `ARP_ASSERT_NEXT(a_host_ip_wr, clk, rst_n, host_ip_wr, host_ip_reg == $past(cfg_data[31:0]))

endmodule
